// ----- sv/lmdtf_pkg.sv -----
// Shared types and constants of the lane mask dilate / temporal fuse block.
package lmdtf_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 12;

  // Register and payload widths
  localparam int unsigned FRAME_WIDTH_W  = 12;
  localparam int unsigned FRAME_HEIGHT_W = 10;
  localparam int unsigned START_ROW_W    = 9;
  localparam int unsigned LEVEL_W        = 8;

  // Register values after reset
  localparam int unsigned RST_FRAME_WIDTH  = 1266;
  localparam int unsigned RST_FRAME_HEIGHT = 370;
  localparam logic [START_ROW_W-1:0] RST_START_ROW     = 9'd200;
  localparam logic [LEVEL_W-1:0]     RST_MARK_LEVEL    = 8'd20;
  localparam logic [LEVEL_W-1:0]     RST_DECAY_STEP    = 8'd10;
  localparam logic [LEVEL_W-1:0]     RST_SAT_THRESHOLD = 8'd250;

  // Saturated level
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'hFF;

  // Output queue
  localparam int unsigned OUT_DEPTH = 3;
  localparam int unsigned OUT_PTR_W = 2;
  localparam int unsigned OUT_CNT_W = 2;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_START_ROW     = 3'd2,
    CFG_MARK_LEVEL    = 3'd3,
    CFG_DECAY_STEP    = 3'd4,
    CFG_SAT_THRESHOLD = 3'd5
  } cfg_reg_e;

  // One result request
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               frame_last;
  } result_t;

endpackage

// ----- sv/lane_mask_dilate_temporal_fuse_core.sv -----
// Channel   Direction  Handshake                  Payload
// cfg       in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
// in        in         in_valid_i / in_stall_o    track_bit_i, flush_i
// out       out        out_valid_o / out_stall_i  level_o, frame_last_o
//
// One request per clock while in_stall_o is low: the bank read and the frame memory read are issued at
// acceptance, fuse and frame memory write-back follow in the next cycle, and the result passes
// through the fuse stage register and then the output queue before it reaches out_valid_o.
// Reset clears counters and control only; line banks and frame memory are not
// cleared and need no clearing pass.
// in_stall_o rises when the output queue count plus the fuse stage entry reach the queue depth of three.
module lane_mask_dilate_temporal_fuse_core #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 512,
  parameter int unsigned RADIUS     = 3
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lmdtf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lmdtf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 track_bit_i,
  input  logic                                 flush_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [lmdtf_pkg::LEVEL_W-1:0]        level_o,
  output logic                                 frame_last_o
);

  localparam int unsigned WIN        = 2 * RADIUS + 1;
  localparam int unsigned SW         = $clog2(WIN);
  localparam int unsigned KW         = $clog2(3 * WIN);
  localparam int unsigned CW         = $clog2(MAX_WIDTH);
  localparam int unsigned WV         = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW         = $clog2(MAX_HEIGHT);
  localparam int unsigned HV         = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned XW         = $clog2(MAX_WIDTH + 2 * RADIUS + 2);
  localparam int unsigned YW         = $clog2(MAX_HEIGHT + 2 * RADIUS + 2);
  localparam int unsigned LAG_W      = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);
  localparam int unsigned AW         = RW + CW;
  localparam int unsigned BANK_DEPTH = 2 ** CW;
  localparam int unsigned PREV_DEPTH = 2 ** AW;
  localparam int unsigned HWIN_W     = 2 * RADIUS;
  localparam int unsigned WCMP = (WV > lmdtf_pkg::FRAME_WIDTH_W) ? WV : lmdtf_pkg::FRAME_WIDTH_W;
  localparam int unsigned HCMP = (HV > lmdtf_pkg::FRAME_HEIGHT_W) ?
                                 HV : lmdtf_pkg::FRAME_HEIGHT_W;
  localparam int unsigned SCMP = (RW > lmdtf_pkg::START_ROW_W) ? RW : lmdtf_pkg::START_ROW_W;
  localparam int unsigned W_RST = (lmdtf_pkg::RST_FRAME_WIDTH > MAX_WIDTH) ?
                                  MAX_WIDTH : lmdtf_pkg::RST_FRAME_WIDTH;
  localparam int unsigned H_RST = (lmdtf_pkg::RST_FRAME_HEIGHT > MAX_HEIGHT) ?
                                  MAX_HEIGHT : lmdtf_pkg::RST_FRAME_HEIGHT;
  localparam int unsigned LAG_RST = RADIUS * W_RST + RADIUS;

  // Configuration registers (geometry kept clamped)
  logic [WV-1:0]                         w_q, w_d;
  logic [HV-1:0]                         h_q, h_d;
  logic [LAG_W-1:0]                      lag_q, lag_d;
  logic [lmdtf_pkg::START_ROW_W-1:0]     start_q;
  logic [lmdtf_pkg::LEVEL_W-1:0]         mark_q, decay_q, thr_q;
  logic                                  geo_wr;
  logic [WCMP-1:0]                       wval;
  logic [HCMP-1:0]                       hval;

  // Stream position state
  logic [CW-1:0]    in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RW-1:0]    in_row_q, in_row_d, out_row_q, out_row_d;
  logic [SW-1:0]    in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic [LAG_W-1:0] lead_q, lead_d;
  logic             all_in_q, all_in_d;
  logic             ffd_q, ffd_d;

  // Acceptance stage
  logic             in_acc, pix_acc, fl_acc, abandon, emit;
  logic [CW-1:0]    o_col;
  logic [RW-1:0]    o_row;
  logic [SW-1:0]    o_slot;
  logic [LAG_W-1:0] lead_eff;
  logic             in_col_end, in_row_end, frame_end;
  logic             o_col_end, o_row_end, out_wrap;
  logic [XW-1:0]    rd_col;
  logic             col_ok, below, fwd_hit;
  logic [WIN-1:0]   rowmask;
  logic [AW-1:0]    addr0;

  // Fuse stage
  logic                          s1_valid_q;
  logic [WIN-1:0]                s1_rowmask_q;
  logic                          s1_col_ok_q, s1_col0_q, s1_ffd_q, s1_below_q, s1_last_q;
  logic                          s1_fwd_q, s1_fwd_bit_q;
  logic [SW-1:0]                 s1_fwd_slot_q;
  logic [AW-1:0]                 s1_addr_q;
  logic [WIN-1:0]                col_bits;
  logic [HWIN_W-1:0]             hwin_q;
  logic                          new_bit, d_nz;
  logic [lmdtf_pkg::LEVEL_W-1:0] d_val, p_val, v_val, sat_val, prev_rd_q;
  logic [lmdtf_pkg::LEVEL_W:0]   sum_val;
  logic                          wr_last_v_q;
  logic [AW-1:0]                 wr_last_addr_q;
  logic [lmdtf_pkg::LEVEL_W-1:0] wr_last_data_q;
  logic [lmdtf_pkg::LEVEL_W-1:0] prev_mem [PREV_DEPTH];

  // Output queue
  lmdtf_pkg::result_t                res_push, res_out;
  logic [lmdtf_pkg::OUT_CNT_W-1:0]   out_cnt;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = ((3'(out_cnt) + 3'(s1_valid_q)) >= 3'(lmdtf_pkg::OUT_DEPTH));

  // Decode configuration writes and clamp geometry
  always_comb begin
    wval   = WCMP'(cfg_data_i[lmdtf_pkg::FRAME_WIDTH_W-1:0]);
    hval   = HCMP'(cfg_data_i[lmdtf_pkg::FRAME_HEIGHT_W-1:0]);
    geo_wr = 1'b0;
    w_d    = w_q;
    h_d    = h_q;
    if (cfg_valid_i) begin
      case (lmdtf_pkg::cfg_reg_e'(cfg_index_i))
        lmdtf_pkg::CFG_FRAME_WIDTH: begin
          geo_wr = 1'b1;
          if (wval == '0) begin
            w_d = WV'(1);
          end else if (wval > WCMP'(MAX_WIDTH)) begin
            w_d = WV'(MAX_WIDTH);
          end else begin
            w_d = wval[WV-1:0];
          end
        end
        lmdtf_pkg::CFG_FRAME_HEIGHT: begin
          geo_wr = 1'b1;
          if (hval == '0) begin
            h_d = HV'(1);
          end else if (hval > HCMP'(MAX_HEIGHT)) begin
            h_d = HV'(MAX_HEIGHT);
          end else begin
            h_d = hval[HV-1:0];
          end
        end
        default: ;
      endcase
    end
    lag_d = LAG_W'(w_d) * LAG_W'(RADIUS) + LAG_W'(RADIUS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= WV'(W_RST);
      h_q     <= HV'(H_RST);
      lag_q   <= LAG_W'(LAG_RST);
      start_q <= lmdtf_pkg::RST_START_ROW;
      mark_q  <= lmdtf_pkg::RST_MARK_LEVEL;
      decay_q <= lmdtf_pkg::RST_DECAY_STEP;
      thr_q   <= lmdtf_pkg::RST_SAT_THRESHOLD;
    end else begin
      w_q   <= w_d;
      h_q   <= h_d;
      lag_q <= lag_d;
      if (cfg_valid_i) begin
        case (lmdtf_pkg::cfg_reg_e'(cfg_index_i))
          lmdtf_pkg::CFG_START_ROW:     start_q <= cfg_data_i[lmdtf_pkg::START_ROW_W-1:0];
          lmdtf_pkg::CFG_MARK_LEVEL:    mark_q  <= cfg_data_i[lmdtf_pkg::LEVEL_W-1:0];
          lmdtf_pkg::CFG_DECAY_STEP:    decay_q <= cfg_data_i[lmdtf_pkg::LEVEL_W-1:0];
          lmdtf_pkg::CFG_SAT_THRESHOLD: thr_q   <= cfg_data_i[lmdtf_pkg::LEVEL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Decide emission and the output pixel for this request
  always_comb begin
    logic [KW-1:0] kk;
    kk         = '0;
    in_acc     = in_valid_i && !in_stall_o;
    pix_acc    = in_acc && !flush_i;
    fl_acc     = in_acc && flush_i;
    abandon    = pix_acc && all_in_q;
    o_col      = abandon ? '0 : out_col_q;
    o_row      = abandon ? '0 : out_row_q;
    o_slot     = abandon ? '0 : out_slot_q;
    lead_eff   = abandon ? '0 : lead_q;
    in_col_end = (WV'(in_col_q) + WV'(1)) >= w_q;
    in_row_end = (HV'(in_row_q) + HV'(1)) >= h_q;
    frame_end  = in_col_end && in_row_end;
    emit       = pix_acc ? (frame_end || (lead_eff >= lag_q)) : (fl_acc && all_in_q);
    o_col_end  = (WV'(o_col) + WV'(1)) >= w_q;
    o_row_end  = (HV'(o_row) + HV'(1)) >= h_q;
    out_wrap   = o_col_end && o_row_end;
    rd_col     = XW'(o_col) + XW'(RADIUS);
    col_ok     = (XW'(o_col) + XW'(2 * RADIUS + 1)) <= XW'(w_q);
    below      = SCMP'(o_row) < SCMP'(start_q);
    fwd_hit    = pix_acc && (in_col_q == rd_col[CW-1:0]);
    addr0      = {o_row, o_col};
    // Mark banks whose row lies inside the window and away from the borders
    for (int b = 0; b < WIN; b++) begin
      kk = KW'(b + WIN + RADIUS) - KW'(o_slot);
      if (kk >= KW'(2 * WIN)) begin
        kk = kk - KW'(2 * WIN);
      end else if (kk >= KW'(WIN)) begin
        kk = kk - KW'(WIN);
      end
      rowmask[b] = ((YW'(o_row) + YW'(kk)) >= YW'(2 * RADIUS)) &&
                   ((YW'(o_row) + YW'(kk) + YW'(1)) <= YW'(h_q));
    end
  end

  // Advance input and output positions
  always_comb begin
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_slot_d  = in_slot_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_slot_d = out_slot_q;
    lead_d     = lead_q;
    all_in_d   = all_in_q;
    ffd_d      = ffd_q;
    if (pix_acc) begin
      out_col_d  = o_col;
      out_row_d  = o_row;
      out_slot_d = o_slot;
      all_in_d   = frame_end;
      lead_d     = emit ? lead_eff : lead_eff + 1'b1;
      if (in_col_end) begin
        in_col_d = '0;
        if (in_row_end) begin
          in_row_d  = '0;
          in_slot_d = '0;
        end else begin
          in_row_d  = in_row_q + 1'b1;
          in_slot_d = (in_slot_q == SW'(WIN - 1)) ? '0 : in_slot_q + 1'b1;
        end
      end else begin
        in_col_d = in_col_q + 1'b1;
      end
    end
    if (emit) begin
      if (o_col_end) begin
        out_col_d = '0;
        if (o_row_end) begin
          out_row_d  = '0;
          out_slot_d = '0;
          all_in_d   = 1'b0;
          ffd_d      = 1'b1;
          lead_d     = '0;
        end else begin
          out_row_d  = o_row + 1'b1;
          out_slot_d = (o_slot == SW'(WIN - 1)) ? '0 : o_slot + 1'b1;
        end
      end else begin
        out_col_d = o_col + 1'b1;
      end
    end
    // Restart the stream on a geometry write
    if (geo_wr) begin
      in_col_d   = '0;
      in_row_d   = '0;
      in_slot_d  = '0;
      out_col_d  = '0;
      out_row_d  = '0;
      out_slot_d = '0;
      lead_d     = '0;
      all_in_d   = 1'b0;
      ffd_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
      lead_q     <= '0;
      all_in_q   <= 1'b0;
      ffd_q      <= 1'b0;
      s1_valid_q <= 1'b0;
      wr_last_v_q <= 1'b0;
    end else begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_slot_q  <= in_slot_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_slot_q <= out_slot_d;
      lead_q     <= lead_d;
      all_in_q   <= all_in_d;
      ffd_q      <= ffd_d;
      s1_valid_q <= emit;
      if (s1_valid_q) begin
        wr_last_v_q <= 1'b1;
      end
    end
  end

  // Hold the fuse stage payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_rowmask_q  <= rowmask;
      s1_col_ok_q   <= col_ok;
      s1_col0_q     <= (o_col == '0);
      s1_ffd_q      <= ffd_q;
      s1_below_q    <= below;
      s1_last_q     <= out_wrap;
      s1_fwd_q      <= fwd_hit;
      s1_fwd_bit_q  <= track_bit_i;
      s1_fwd_slot_q <= in_slot_q;
      s1_addr_q     <= addr0;
    end
  end

  // Track line banks: one bank per window row, written by pixel, read by column
  for (genvar gb = 0; gb < WIN; gb++) begin : g_bank
    logic mem [BANK_DEPTH];
    logic rd_q;

    always_ff @(posedge clk_i) begin
      if (pix_acc && (in_slot_q == SW'(gb))) begin
        mem[in_col_q] <= track_bit_i;
      end
      if (emit) begin
        rd_q <= mem[rd_col[CW-1:0]];
      end
    end

    // Take the pixel written alongside the read
    assign col_bits[gb] = (s1_fwd_q && (s1_fwd_slot_q == SW'(gb))) ? s1_fwd_bit_q : rd_q;
  end

  // Dilate: vertical OR of the new column, then horizontal OR over the window
  always_comb begin
    new_bit = s1_col_ok_q && (|(col_bits & s1_rowmask_q));
    d_nz    = new_bit || (!s1_col0_q && (|hwin_q));
    d_val   = d_nz ? mark_q : '0;
    p_val   = (wr_last_v_q && (wr_last_addr_q == s1_addr_q)) ? wr_last_data_q : prev_rd_q;
    sum_val = {1'b0, d_val} + {1'b0, p_val};
    sat_val = sum_val[lmdtf_pkg::LEVEL_W] ? lmdtf_pkg::LEVEL_FULL :
              sum_val[lmdtf_pkg::LEVEL_W-1:0];
    // Fuse with the stored previous frame
    if (!s1_ffd_q) begin
      v_val = d_val;
    end else if (s1_below_q) begin
      v_val = '0;
    end else if ((d_val != '0) && (p_val != '0)) begin
      v_val = (sat_val > thr_q) ? lmdtf_pkg::LEVEL_FULL : sat_val;
    end else if (d_val != '0) begin
      v_val = (d_val >= decay_q) ? d_val - decay_q : '0;
    end else begin
      v_val = (p_val > decay_q) ? p_val - decay_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      hwin_q <= s1_col0_q ? {{(HWIN_W - 1){1'b0}}, new_bit} :
                            {hwin_q[HWIN_W-2:0], new_bit};
    end
  end

  // Frame memory: read at acceptance, write back from the fuse stage
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      prev_mem[s1_addr_q] <= v_val;
      wr_last_addr_q      <= s1_addr_q;
      wr_last_data_q      <= v_val;
    end
    if (emit) begin
      prev_rd_q <= prev_mem[addr0];
    end
  end

  assign res_push.level      = v_val;
  assign res_push.frame_last = s1_last_q;

  lmdtf_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q),
    .push_data_i (res_push),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (res_out),
    .count_o     (out_cnt)
  );

  assign level_o      = res_out.level;
  assign frame_last_o = res_out.frame_last;

endmodule

// ----- sv/lmdtf_out_fifo.sv -----
// Small result queue that decouples the fuse stage from the output stall.
module lmdtf_out_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  lmdtf_pkg::result_t                  push_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output lmdtf_pkg::result_t                  out_data_o,
  output logic [lmdtf_pkg::OUT_CNT_W-1:0]     count_o
);

  lmdtf_pkg::result_t                 mem_q [lmdtf_pkg::OUT_DEPTH];
  logic [lmdtf_pkg::OUT_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [lmdtf_pkg::OUT_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [lmdtf_pkg::OUT_CNT_W-1:0]    cnt_q, cnt_d;
  logic                               pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign count_o     = cnt_q;
  assign pop         = out_valid_o && !out_stall_i;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == lmdtf_pkg::OUT_PTR_W'(lmdtf_pkg::OUT_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == lmdtf_pkg::OUT_PTR_W'(lmdtf_pkg::OUT_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
